@@ sv/rxaf_pkg.sv @@
// shared types, constants and register codes for the rs485 receive address filter
package rxaf_pkg;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OWN_ADDRESS = 3'd0,
      CSR_GROUP_A     = 3'd1,
      CSR_GROUP_B     = 3'd2,
      CSR_GROUP_C     = 3'd3,
      CSR_GROUP_D     = 3'd4
   } rxaf_csr_index_type;

   // default sizes
   localparam int MAX_BYTES_DEFAULT  = 32;
   localparam int SLOT_COUNT_DEFAULT = 16;

   // address classes
   localparam logic [7:0] MCAST_MASK     = 8'hC0;
   localparam logic [7:0] RESERVED_MASK  = 8'hF0;
   localparam int         GROUP_WIDTH    = 6;
   localparam int         HEADER_LENGTH  = 2;

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_GAP  = 1'b1
   } rxaf_cmd_type;

   typedef struct packed {
      logic [7:0]             own_address;
      logic [GROUP_WIDTH-1:0] group_a;
      logic [GROUP_WIDTH-1:0] group_b;
      logic [GROUP_WIDTH-1:0] group_c;
      logic [GROUP_WIDTH-1:0] group_d;
   } rxaf_cfg_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
      logic       slot_offered;
      logic [3:0] offered_slot;
   } rxaf_item_type;

   typedef struct packed {
      logic       write_en;
      logic [3:0] write_slot;
      logic [4:0] write_offset;
      logic [7:0] write_data;
      logic       slot_taken;
      logic       packet_done;
      logic [3:0] done_slot;
      logic [5:0] done_length;
      logic [7:0] overrun_count;
      logic [7:0] protocol_error_count;
   } rxaf_result_type;

endpackage

@@ sv/rxaf_channels.sv @@
// request and response channel interfaces
interface rxaf_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;
   logic       slot_offered;
   logic [3:0] offered_slot;

   modport source (output valid, cmd, rx_byte, slot_offered, offered_slot, input ready);
   modport sink   (input valid, cmd, rx_byte, slot_offered, offered_slot, output ready);
endinterface

interface rxaf_rsp_if;
   logic       valid;
   logic       ready;
   logic       write_en;
   logic [3:0] write_slot;
   logic [4:0] write_offset;
   logic [7:0] write_data;
   logic       slot_taken;
   logic       packet_done;
   logic [3:0] done_slot;
   logic [5:0] done_length;
   logic [7:0] overrun_count;
   logic [7:0] protocol_error_count;

   modport source (output valid, write_en, write_slot, write_offset, write_data, slot_taken,
                   packet_done, done_slot, done_length, overrun_count,
                   protocol_error_count, input ready);
   modport sink   (input valid, write_en, write_slot, write_offset, write_data, slot_taken,
                   packet_done, done_slot, done_length, overrun_count,
                   protocol_error_count, output ready);
endinterface

@@ sv/rs485_rx_address_filter_framer_top.sv @@
// top level of the rs485 receive address filter and packet framer
//
//   channel | direction | handshake             | carries
//   req_ch  | in        | valid / ready         | cmd, rx_byte, slot_offered, offered_slot
//   rsp_ch  | out       | valid / ready         | buffer write, slot claim, completion, counts
//   csr_*   | in        | csr_write_en          | csr_index, csr_write_data (no read-back)
//
// one transaction in, exactly one transaction out; a new request is taken every cycle unless the response stalls
// each request passes through the request register, then framer logic into the response register
// framer state advances when the request register moves into the response register
// a stalled response holds both stages; the request register still fills behind it
// reset is synchronous and clears configuration, framer state, counters and valids
module rs485_rx_address_filter_framer_top #(
   parameter int MAX_BYTES  = rxaf_pkg::MAX_BYTES_DEFAULT,
   parameter int SLOT_COUNT = rxaf_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rxaf_req_if.sink                             req_ch,
   rxaf_rsp_if.source                           rsp_ch,
   input  logic                                 csr_write_en,
   input  logic [rxaf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rxaf_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   rxaf_pkg::rxaf_cfg_type    cfg;
   rxaf_pkg::rxaf_item_type   req_item_ff;
   rxaf_pkg::rxaf_result_type rsp_result_ff;
   rxaf_pkg::rxaf_result_type step_result;
   logic                      req_valid_ff, req_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      req_accept;
   logic                      advance;
   logic                      dest_match;

   // configuration registers
   rxaf_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   // handshake: request stage moves on when the response register is free or draining
   always_comb begin
      advance      = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
      req_accept   = req_ch.valid && req_ch.ready;
      req_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   assign req_ch.ready = !req_valid_ff || advance;

   // request register, payload needs no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_item_ff.cmd          <= req_ch.cmd;
         req_item_ff.rx_byte      <= req_ch.rx_byte;
         req_item_ff.slot_offered <= req_ch.slot_offered;
         req_item_ff.offered_slot <= req_ch.offered_slot;
      end
   end

   // destination filter looks at the registered byte
   rxaf_dest_match u_dest_match (
      .dest  (req_item_ff.rx_byte),
      .cfg   (cfg),
      .match (dest_match)
   );

   // framer state machine and counters
   rxaf_framer #(
      .MAX_BYTES  (MAX_BYTES),
      .SLOT_COUNT (SLOT_COUNT)
   ) u_framer (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .item       (req_item_ff),
      .dest_match (dest_match),
      .result     (step_result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= step_result;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.write_en             = rsp_result_ff.write_en;
   assign rsp_ch.write_slot           = rsp_result_ff.write_slot;
   assign rsp_ch.write_offset         = rsp_result_ff.write_offset;
   assign rsp_ch.write_data           = rsp_result_ff.write_data;
   assign rsp_ch.slot_taken           = rsp_result_ff.slot_taken;
   assign rsp_ch.packet_done          = rsp_result_ff.packet_done;
   assign rsp_ch.done_slot            = rsp_result_ff.done_slot;
   assign rsp_ch.done_length          = rsp_result_ff.done_length;
   assign rsp_ch.overrun_count        = rsp_result_ff.overrun_count;
   assign rsp_ch.protocol_error_count = rsp_result_ff.protocol_error_count;

endmodule

@@ sv/rxaf_csr.sv @@
// configuration registers: own address and four multicast groups
module rxaf_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [rxaf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rxaf_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   output rxaf_pkg::rxaf_cfg_type                cfg
);

   rxaf_pkg::rxaf_cfg_type cfg_ff;
   rxaf_pkg::rxaf_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            rxaf_pkg::CSR_OWN_ADDRESS: cfg_in.own_address = csr_write_data;
            rxaf_pkg::CSR_GROUP_A: cfg_in.group_a = csr_write_data[rxaf_pkg::GROUP_WIDTH-1:0];
            rxaf_pkg::CSR_GROUP_B: cfg_in.group_b = csr_write_data[rxaf_pkg::GROUP_WIDTH-1:0];
            rxaf_pkg::CSR_GROUP_C: cfg_in.group_c = csr_write_data[rxaf_pkg::GROUP_WIDTH-1:0];
            rxaf_pkg::CSR_GROUP_D: cfg_in.group_d = csr_write_data[rxaf_pkg::GROUP_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/rxaf_dest_match.sv @@
// destination address filter: own, broadcast, promiscuous and multicast groups
module rxaf_dest_match (
   input  logic [7:0]             dest,
   input  rxaf_pkg::rxaf_cfg_type cfg,
   output logic                   match
);

   logic [rxaf_pkg::GROUP_WIDTH-1:0] group_id;
   logic                             direct_hit;
   logic                             is_mcast;
   logic                             group_hit;

   always_comb begin
      group_id   = dest[rxaf_pkg::GROUP_WIDTH-1:0];
      direct_hit = (dest == cfg.own_address) || (dest == 8'd0) || (cfg.own_address == 8'd0);
      is_mcast   = ((dest & rxaf_pkg::MCAST_MASK) == rxaf_pkg::MCAST_MASK)
                && ((dest & rxaf_pkg::RESERVED_MASK) != rxaf_pkg::RESERVED_MASK);
      group_hit  = (group_id == cfg.group_a) || (group_id == cfg.group_b)
                || (group_id == cfg.group_c) || (group_id == cfg.group_d);
      match      = direct_hit || (is_mcast && group_hit);
   end

endmodule

@@ sv/rxaf_framer.sv @@
// framer state, error counters and per-transaction result logic
module rxaf_framer #(
   parameter int MAX_BYTES  = rxaf_pkg::MAX_BYTES_DEFAULT,
   parameter int SLOT_COUNT = rxaf_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  rxaf_pkg::rxaf_item_type   item,
   input  logic                      dest_match,
   output rxaf_pkg::rxaf_result_type result
);

   localparam int         CountWidth = $clog2(MAX_BYTES + 1);
   localparam logic [CountWidth-1:0] CountMax   = CountWidth'(MAX_BYTES);
   localparam logic [CountWidth-1:0] CountStart = CountWidth'(rxaf_pkg::HEADER_LENGTH);
   localparam logic [7:0] SlotLimit  = 8'(SLOT_COUNT);

   logic [7:0]            source_hold_ff,  source_hold_in;
   logic                  receiving_ff,    receiving_in;
   logic [3:0]            current_slot_ff, current_slot_in;
   logic [CountWidth-1:0] byte_count_ff,   byte_count_in;
   logic                  ignoring_ff,     ignoring_in;
   logic [7:0]            overruns_ff,     overruns_in;
   logic [7:0]            size_errors_ff,  size_errors_in;

   logic [CountWidth+7:0] count_wide;
   logic                  slot_ok;

   always_comb begin
      count_wide      = {8'd0, byte_count_ff};
      slot_ok         = item.slot_offered && ({4'd0, item.offered_slot} < SlotLimit);

      source_hold_in  = source_hold_ff;
      receiving_in    = receiving_ff;
      current_slot_in = current_slot_ff;
      byte_count_in   = byte_count_ff;
      ignoring_in     = ignoring_ff;
      overruns_in     = overruns_ff;
      size_errors_in  = size_errors_ff;
      result          = '0;

      if (item.cmd == rxaf_pkg::CMD_GAP) begin
         if (receiving_ff) begin
            // source byte goes to offset zero together with completion
            result.packet_done  = 1'b1;
            result.done_slot    = current_slot_ff;
            result.done_length  = count_wide[5:0];
            result.write_en     = 1'b1;
            result.write_slot   = current_slot_ff;
            result.write_offset = 5'd0;
            result.write_data   = source_hold_ff;
         end
         source_hold_in  = 8'd0;
         receiving_in    = 1'b0;
         current_slot_in = 4'd0;
         byte_count_in   = '0;
         ignoring_in     = 1'b0;
      end else if (!ignoring_ff) begin
         if (source_hold_ff == 8'd0) begin
            source_hold_in = item.rx_byte;
         end else if (!receiving_ff) begin
            if (dest_match) begin
               if (slot_ok) begin
                  receiving_in        = 1'b1;
                  current_slot_in     = item.offered_slot;
                  byte_count_in       = CountStart;
                  result.slot_taken   = 1'b1;
                  result.write_en     = 1'b1;
                  result.write_slot   = item.offered_slot;
                  result.write_offset = 5'd1;
                  result.write_data   = item.rx_byte;
               end else begin
                  overruns_in = overruns_ff + 8'd1;
                  ignoring_in = 1'b1;
               end
            end else begin
               ignoring_in = 1'b1;
            end
         end else if (byte_count_ff < CountMax) begin
            result.write_en     = 1'b1;
            result.write_slot   = current_slot_ff;
            result.write_offset = count_wide[4:0];
            result.write_data   = item.rx_byte;
            byte_count_in       = byte_count_ff + CountWidth'(1);
         end else begin
            size_errors_in = size_errors_ff + 8'd1;
         end
      end

      result.overrun_count        = overruns_in;
      result.protocol_error_count = size_errors_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_hold_ff  <= 8'd0;
         receiving_ff    <= 1'b0;
         current_slot_ff <= 4'd0;
         byte_count_ff   <= '0;
         ignoring_ff     <= 1'b0;
         overruns_ff     <= 8'd0;
         size_errors_ff  <= 8'd0;
      end else if (step_en) begin
         source_hold_ff  <= source_hold_in;
         receiving_ff    <= receiving_in;
         current_slot_ff <= current_slot_in;
         byte_count_ff   <= byte_count_in;
         ignoring_ff     <= ignoring_in;
         overruns_ff     <= overruns_in;
         size_errors_ff  <= size_errors_in;
      end
   end

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the rs485 receive address filter and packet framer
module testbench;

   // sizes the block is built with, also used by the framer prediction
   localparam int MAX_BYTES  = rxaf_pkg::MAX_BYTES_DEFAULT;
   localparam int SLOT_COUNT = rxaf_pkg::SLOT_COUNT_DEFAULT;

   // run control
   localparam int unsigned RANDOM_PER_PHASE = 140;
   localparam int unsigned SETTLE_CYCLES    = 6;
   localparam int unsigned HOLD_AFTER       = 40;
   localparam int unsigned HOLD_CYCLES      = 64;
   localparam int unsigned LIMIT_CYCLES     = 200000;
   localparam int unsigned REPORT_LIMIT     = 10;

   localparam logic [7:0] BROADCAST_ADDRESS = 8'h00;
   localparam logic [rxaf_pkg::CSR_INDEX_WIDTH-1:0] CSR_INDEX_UNMAPPED = 3'd7;

   // framer state as the prediction sees it
   typedef struct {
      logic [7:0] source;
      logic       receiving;
      logic [3:0] slot;
      logic [5:0] count;
      logic       ignoring;
      logic [7:0] overruns;
      logic [7:0] size_errors;
   } framer_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 csr_write_en   = 1'b0;
   logic [rxaf_pkg::CSR_INDEX_WIDTH-1:0] csr_index      = '0;
   logic [rxaf_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   rxaf_req_if req_ch ();
   rxaf_rsp_if rsp_ch ();

   rs485_rx_address_filter_framer_top #(
      .MAX_BYTES  (MAX_BYTES),
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #2 clock = ~clock;

   // filter registers and framer state mirrored on the testbench side
   rxaf_pkg::rxaf_cfg_type filter_cfg = '0;
   framer_state_type       framer     = '{default: '0};

   // bytes and gaps waiting to be offered, and writes the framer must produce
   rxaf_pkg::rxaf_item_type   pending_bytes[$];
   rxaf_pkg::rxaf_result_type buffer_writes_due[$];
   rxaf_pkg::rxaf_item_type   on_wire;

   // sender gap and receiver stall countdowns, plus the long receiver hold-off
   int unsigned req_gap       = 0;
   int unsigned rsp_stall     = 0;
   logic        rsp_hold      = 1'b0;
   bit          quiet_sender  = 1'b0;
   bit          quiet_receiver = 1'b0;

   int unsigned cycle_count     = 0;
   int unsigned items_queued    = 0;
   int unsigned items_accepted  = 0;
   int unsigned results_seen    = 0;
   int unsigned mismatches      = 0;
   int unsigned packets_done    = 0;
   int unsigned slots_claimed   = 0;
   int unsigned dropped_packets = 0;
   int unsigned oversize_bytes  = 0;
   int unsigned dests_rejected  = 0;

   // every block input at a known value from time zero
   initial begin
      req_ch.valid        = 1'b0;
      req_ch.cmd          = rxaf_pkg::CMD_BYTE;
      req_ch.rx_byte      = '0;
      req_ch.slot_offered = 1'b0;
      req_ch.offered_slot = '0;
      rsp_ch.ready        = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // framer prediction
   // ---------------------------------------------------------------------------------

   // destination check: own address, broadcast, promiscuous node, or multicast group
   function automatic bit dest_accepted(logic [7:0] dest);
      logic [rxaf_pkg::GROUP_WIDTH-1:0] grp;
      grp = dest[rxaf_pkg::GROUP_WIDTH-1:0];
      if (dest == filter_cfg.own_address || dest == BROADCAST_ADDRESS ||
          filter_cfg.own_address == BROADCAST_ADDRESS) begin
         return 1'b1;
      end
      // only the multicast range counts, the reserved range above it never does
      if ((dest & rxaf_pkg::MCAST_MASK) != rxaf_pkg::MCAST_MASK ||
          (dest & rxaf_pkg::RESERVED_MASK) == rxaf_pkg::RESERVED_MASK) begin
         return 1'b0;
      end
      return grp == filter_cfg.group_a || grp == filter_cfg.group_b ||
             grp == filter_cfg.group_c || grp == filter_cfg.group_d;
   endfunction

   // advance the framer by one transaction and return the response it must give
   function automatic rxaf_pkg::rxaf_result_type frame_step(rxaf_pkg::rxaf_item_type it);
      rxaf_pkg::rxaf_result_type r;
      r = '0;
      if (it.cmd == rxaf_pkg::CMD_GAP) begin
         // gap closes an accepted packet: source byte goes to offset zero now
         if (framer.receiving) begin
            r.packet_done  = 1'b1;
            r.done_slot    = framer.slot;
            r.done_length  = framer.count;
            r.write_en     = 1'b1;
            r.write_slot   = framer.slot;
            r.write_offset = '0;
            r.write_data   = framer.source;
            packets_done++;
         end
         framer.source    = '0;
         framer.receiving = 1'b0;
         framer.slot      = '0;
         framer.count     = '0;
         framer.ignoring  = 1'b0;
      end else if (!framer.ignoring) begin
         if (framer.source == '0) begin
            // a zero source leaves the framer idle
            framer.source = it.rx_byte;
         end else if (!framer.receiving) begin
            if (dest_accepted(it.rx_byte)) begin
               if (it.slot_offered && 32'(it.offered_slot) < SLOT_COUNT) begin
                  framer.receiving = 1'b1;
                  framer.slot      = it.offered_slot;
                  framer.count     = 6'(rxaf_pkg::HEADER_LENGTH);
                  r.slot_taken     = 1'b1;
                  r.write_en       = 1'b1;
                  r.write_slot     = it.offered_slot;
                  r.write_offset   = 5'd1;
                  r.write_data     = it.rx_byte;
                  slots_claimed++;
               end else begin
                  // no buffer free: packet dropped and counted
                  framer.overruns = framer.overruns + 8'd1;
                  framer.ignoring = 1'b1;
                  dropped_packets++;
               end
            end else begin
               framer.ignoring = 1'b1;
               dests_rejected++;
            end
         end else if (32'(framer.count) < MAX_BYTES) begin
            r.write_en     = 1'b1;
            r.write_slot   = framer.slot;
            r.write_offset = framer.count[4:0];
            r.write_data   = it.rx_byte;
            framer.count   = framer.count + 6'd1;
         end else begin
            // packet already full, byte dropped
            framer.size_errors = framer.size_errors + 8'd1;
            oversize_bytes++;
         end
      end
      r.overrun_count        = framer.overruns;
      r.protocol_error_count = framer.size_errors;
      return r;
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch in response %0d, %s: expected %0d, got %0d",
                     results_seen, field, want, got);
         end
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // request driver: offers queued transactions, predicts each one as it is taken
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      rxaf_pkg::rxaf_item_type next_item;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap      <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            buffer_writes_due.push_back(frame_step(on_wire));
            items_accepted++;
         end
         // channel is free when nothing is offered or the offer was just taken
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_ch.valid <= 1'b0;
               req_gap      <= req_gap - 1;
            end else if (pending_bytes.size() > 0) begin
               next_item           = pending_bytes.pop_front();
               on_wire             <= next_item;
               req_ch.cmd          <= next_item.cmd;
               req_ch.rx_byte      <= next_item.rx_byte;
               req_ch.slot_offered <= next_item.slot_offered;
               req_ch.offered_slot <= next_item.offered_slot;
               req_ch.valid        <= 1'b1;
               req_gap             <= quiet_sender ? 0 : $urandom_range(0, 4);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // response monitor: checks every taken transaction against the oldest prediction
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      rxaf_pkg::rxaf_result_type want;
      int unsigned               wait_n;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else begin
         wait_n = rsp_stall;
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (buffer_writes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("response %0d arrived with no transaction outstanding",
                           results_seen);
               end
            end else begin
               want = buffer_writes_due.pop_front();
               check_field("write_en", 32'(want.write_en), 32'(rsp_ch.write_en));
               check_field("write_slot", 32'(want.write_slot), 32'(rsp_ch.write_slot));
               check_field("write_offset", 32'(want.write_offset),
                           32'(rsp_ch.write_offset));
               check_field("write_data", 32'(want.write_data), 32'(rsp_ch.write_data));
               check_field("slot_taken", 32'(want.slot_taken), 32'(rsp_ch.slot_taken));
               check_field("packet_done", 32'(want.packet_done), 32'(rsp_ch.packet_done));
               check_field("done_slot", 32'(want.done_slot), 32'(rsp_ch.done_slot));
               check_field("done_length", 32'(want.done_length), 32'(rsp_ch.done_length));
               check_field("overrun_count", 32'(want.overrun_count),
                           32'(rsp_ch.overrun_count));
               check_field("protocol_error_count", 32'(want.protocol_error_count),
                           32'(rsp_ch.protocol_error_count));
            end
            wait_n = quiet_receiver ? 0 : $urandom_range(0, 4);
         end else if (wait_n > 0) begin
            wait_n--;
         end
         rsp_stall    <= wait_n;
         rsp_ch.ready <= (wait_n == 0) && !rsp_hold;
      end
   end

   // long receiver hold-off once traffic is flowing, so the pipe backs up into req_ch
   initial begin : rsp_pressure
      while (results_seen < HOLD_AFTER) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d transactions still outstanding",
                  cycle_count, buffer_writes_due.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------
   task automatic queue_item(rxaf_pkg::rxaf_cmd_type cmd, logic [7:0] data, logic offered,
                             logic [3:0] slot);
      rxaf_pkg::rxaf_item_type it;
      it.cmd          = cmd;
      it.rx_byte      = data;
      it.slot_offered = offered;
      it.offered_slot = slot;
      pending_bytes.push_back(it);
      items_queued++;
   endtask

   // random filler fields for one transaction
   task automatic queue_random_item(rxaf_pkg::rxaf_cmd_type cmd);
      queue_item(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)));
   endtask

   // register write, mirrored into the filter model as it lands
   task automatic csr_write(logic [rxaf_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [7:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         rxaf_pkg::CSR_OWN_ADDRESS: filter_cfg.own_address = data;
         rxaf_pkg::CSR_GROUP_A: filter_cfg.group_a = data[rxaf_pkg::GROUP_WIDTH-1:0];
         rxaf_pkg::CSR_GROUP_B: filter_cfg.group_b = data[rxaf_pkg::GROUP_WIDTH-1:0];
         rxaf_pkg::CSR_GROUP_C: filter_cfg.group_c = data[rxaf_pkg::GROUP_WIDTH-1:0];
         rxaf_pkg::CSR_GROUP_D: filter_cfg.group_d = data[rxaf_pkg::GROUP_WIDTH-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic write_filter(logic [7:0] own, logic [7:0] ga, logic [7:0] gb,
                               logic [7:0] gc, logic [7:0] gd);
      csr_write(rxaf_pkg::CSR_OWN_ADDRESS, own);
      csr_write(rxaf_pkg::CSR_GROUP_A, ga);
      csr_write(rxaf_pkg::CSR_GROUP_B, gb);
      csr_write(rxaf_pkg::CSR_GROUP_C, gc);
      csr_write(rxaf_pkg::CSR_GROUP_D, gd);
   endtask

   // random group settings with a given node address
   task automatic write_filter_random(logic [7:0] own);
      write_filter(own, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   // block is idle once nothing is queued, offered or owed
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_ch.valid || buffer_writes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one well-formed packet with random content, opened by a gap
   task automatic queue_packet();
      logic [7:0]                       src;
      logic [7:0]                       dst;
      logic [rxaf_pkg::GROUP_WIDTH-1:0] grp;
      int unsigned                      pick;
      int unsigned                      len;
      queue_random_item(rxaf_pkg::CMD_GAP);
      // occasionally a zero source first, which must not start a packet
      if ($urandom_range(0, 9) == 0) begin
         queue_item(rxaf_pkg::CMD_BYTE, BROADCAST_ADDRESS, 1'($urandom_range(0, 1)),
                    4'($urandom_range(0, 15)));
      end
      src = 8'($urandom_range(1, 255));
      queue_item(rxaf_pkg::CMD_BYTE, src, 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         dst = filter_cfg.own_address;
      end else if (pick < 40) begin
         dst = BROADCAST_ADDRESS;
      end else if (pick < 65) begin
         case ($urandom_range(0, 3))
            0:       grp = filter_cfg.group_a;
            1:       grp = filter_cfg.group_b;
            2:       grp = filter_cfg.group_c;
            default: grp = filter_cfg.group_d;
         endcase
         dst = rxaf_pkg::MCAST_MASK | 8'(grp);
      end else if (pick < 75) begin
         dst = rxaf_pkg::RESERVED_MASK | 8'($urandom_range(0, 15));
      end else begin
         dst = 8'($urandom_range(0, 255));
      end
      // slot mostly on offer, sometimes missing to force an overrun
      queue_item(rxaf_pkg::CMD_BYTE, dst, $urandom_range(0, 99) < 85,
                 4'($urandom_range(0, 15)));
      // mostly short payloads, some that run past the buffer size
      len = ($urandom_range(0, 99) < 15) ? $urandom_range(MAX_BYTES - 4, MAX_BYTES + 2)
                                         : $urandom_range(0, 12);
      repeat (len) begin
         queue_random_item(rxaf_pkg::CMD_BYTE);
      end
   endtask

   task automatic queue_random(int unsigned count);
      int unsigned goal;
      goal = items_queued + count;
      while (items_queued < goal) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: loose bytes and stray gaps, cutting packets short
            repeat ($urandom_range(1, 6)) begin
               queue_random_item(rxaf_pkg::rxaf_cmd_type'($urandom_range(0, 3) == 0));
            end
         end else begin
            queue_packet();
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------------
   initial begin : test_sequence
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part; group a written with upper bits set, only six bits stick
      write_filter(8'h5A, 8'hC1, 8'h3F, 8'h2A, 8'h10);

      // gap with no packet open: nothing reported
      queue_item(rxaf_pkg::CMD_GAP, 8'hA5, 1'b1, 4'hA);
      // zero source is skipped, then own-address packet into the top slot
      queue_item(rxaf_pkg::CMD_BYTE, 8'h00, 1'b0, 4'h0);
      queue_item(rxaf_pkg::CMD_BYTE, 8'h81, 1'b0, 4'h5);
      queue_item(rxaf_pkg::CMD_BYTE, 8'h5A, 1'b1, 4'hF);
      queue_item(rxaf_pkg::CMD_BYTE, 8'h00, 1'b0, 4'h0);
      queue_item(rxaf_pkg::CMD_BYTE, 8'hFF, 1'b1, 4'hF);
      queue_item(rxaf_pkg::CMD_GAP, 8'h5A, 1'b0, 4'h0);
      // broadcast with no free slot: overrun, rest of packet ignored
      queue_item(rxaf_pkg::CMD_BYTE, 8'hFF, 1'b1, 4'h1);
      queue_item(rxaf_pkg::CMD_BYTE, 8'h00, 1'b0, 4'h3);
      queue_item(rxaf_pkg::CMD_BYTE, 8'h77, 1'b1, 4'h2);
      queue_item(rxaf_pkg::CMD_GAP, 8'hFF, 1'b1, 4'hF);
      // multicast group a into slot zero, header-only packet
      queue_item(rxaf_pkg::CMD_BYTE, 8'h12, 1'b0, 4'h0);
      queue_item(rxaf_pkg::CMD_BYTE, 8'hC1, 1'b1, 4'h0);
      queue_item(rxaf_pkg::CMD_GAP, 8'h00, 1'b0, 4'h0);
      // reserved range destination is rejected
      queue_item(rxaf_pkg::CMD_BYTE, 8'h34, 1'b1, 4'h6);
      queue_item(rxaf_pkg::CMD_BYTE, 8'hF1, 1'b1, 4'h6);
      queue_item(rxaf_pkg::CMD_GAP, 8'h00, 1'b0, 4'h0);
      // all-ones destination matches group b bits but sits in the reserved range
      queue_item(rxaf_pkg::CMD_BYTE, 8'h01, 1'b1, 4'h8);
      queue_item(rxaf_pkg::CMD_BYTE, 8'hFF, 1'b1, 4'h8);
      queue_item(rxaf_pkg::CMD_GAP, 8'h00, 1'b0, 4'h0);
      // multicast group d, one payload byte
      queue_item(rxaf_pkg::CMD_BYTE, 8'h40, 1'b0, 4'h0);
      queue_item(rxaf_pkg::CMD_BYTE, 8'hD0, 1'b1, 4'h9);
      queue_item(rxaf_pkg::CMD_BYTE, 8'h3C, 1'b0, 4'h0);
      queue_item(rxaf_pkg::CMD_GAP, 8'h00, 1'b0, 4'h0);
      wait_idle();

      // random part over several filter settings
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               // random node, random groups, idling on both sides
               write_filter_random(8'($urandom_range(1, 254)));
               quiet_sender   = 1'b0;
               quiet_receiver = 1'b0;
            end
            1: begin
               // promiscuous node, groups cleared, full rate both sides
               write_filter(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
               quiet_sender   = 1'b1;
               quiet_receiver = 1'b1;
            end
            2: begin
               // top address, all groups at their top value
               write_filter(8'hFF, 8'hFF, 8'h3F, 8'h3F, 8'h3F);
               quiet_sender   = 1'b0;
               quiet_receiver = 1'b0;
            end
            3: begin
               // unmapped register index must leave the filter alone
               write_filter_random(8'h01);
               csr_write(CSR_INDEX_UNMAPPED, 8'($urandom_range(0, 255)));
               quiet_sender   = 1'b1;
               quiet_receiver = 1'b0;
            end
            default: begin
               write_filter_random(8'($urandom_range(0, 255)));
               quiet_sender   = 1'b0;
               quiet_receiver = 1'b1;
            end
         endcase
         queue_random(RANDOM_PER_PHASE);
         wait_idle();
      end

      $display("covered %0d transactions over six filter settings in %0d cycles",
               items_accepted, cycle_count);
      $display("%0d packets done, %0d slots claimed, %0d dropped, %0d rejected, %0d oversize",
               packets_done, slots_claimed, dropped_packets, dests_rejected, oversize_bytes);
      if (mismatches == 0 && buffer_writes_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
